// ===== hw/rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, control/status word types and helper functions for the buddy allocator
// no dependencies

package bba_pkg;

  localparam int NUM_BLOCKS  = 1024;
  localparam int LOG2_BLOCKS = $clog2(NUM_BLOCKS);
  localparam int ADDR_W      = LOG2_BLOCKS + 1;          // heap index, 1-based
  localparam int TREE_DEPTH  = 2 ** ADDR_W;              // entry 0 unused
  localparam int SIZE_W      = LOG2_BLOCKS + 1;
  localparam int OFF_W       = LOG2_BLOCKS;
  localparam int K_W         = $clog2(LOG2_BLOCKS + 2);  // size exponent, up to log2+1

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic init_step;
    logic load;
    logic check;
    logic desc;
    logic mark;
    logic climb;
    logic fscan;
    logic fail;
    logic emit;
  } bba_cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic init_last;
    logic alloc_fail;
    logic root_target;
    logic desc_last;
    logic at_root;
    logic climb_last;
    logic scan_hit;
  } bba_stat_t;

  // exponent of the smallest power of two not below req, zero counting as one
  function automatic logic [K_W-1:0] ceil_log2(input logic [SIZE_W-1:0] req);
    logic [SIZE_W-1:0] m;
    logic [K_W-1:0]    r;
    m = req - SIZE_W'(1);
    r = '0;
    if (req > SIZE_W'(1)) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (m[i]) r = K_W'(i + 1);
      end
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pow2(input logic [K_W-1:0] k);
    return SIZE_W'(1) << k;
  endfunction

  // first block covered by heap node h of size 2**k
  function automatic logic [OFF_W-1:0] node_offset(input logic [ADDR_W-1:0] h,
                                                   input logic [K_W-1:0]    k);
    logic [ADDR_W+LOG2_BLOCKS-1:0] wide;
    wide = {{LOG2_BLOCKS{1'b0}}, h} << k;
    return wide[OFF_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the buddy allocator: clearing pass, descent, leaf scan, mark and climb
// depends on bba_pkg

module bba_ctrl import bba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      kind,
  input  bba_stat_t stat,
  output bba_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_INIT    = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_CHECK = 3'd2;
  localparam logic [2:0] S_A_DESC  = 3'd3;
  localparam logic [2:0] S_F_SCAN  = 3'd4;
  localparam logic [2:0] S_MARK    = 3'd5;
  localparam logic [2:0] S_CLIMB   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (stat.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = kind ? S_F_SCAN : S_A_CHECK;
        end
      end
      S_A_CHECK: begin
        if (stat.alloc_fail) begin
          cmd.fail  = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.root_target) begin
          state_nxt = S_MARK;
        end else begin
          cmd.check = 1'b1;
          state_nxt = S_A_DESC;
        end
      end
      S_A_DESC: begin
        cmd.desc = 1'b1;
        if (stat.desc_last) state_nxt = S_MARK;
      end
      S_F_SCAN: begin
        if (stat.scan_hit) begin
          state_nxt = S_MARK;
        end else if (stat.at_root) begin
          cmd.fail  = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.fscan = 1'b1;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (stat.at_root) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CLIMB;
        end
      end
      S_CLIMB: begin
        cmd.climb = 1'b1;
        if (stat.climb_last) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/bba_dp.sv =====
`timescale 1ns / 1ps
// datapath for the buddy allocator: free-run tree memory, walk registers and result word
// depends on bba_pkg

module bba_dp import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_cmd_t          cmd,
  input  logic              in_kind,
  input  logic [SIZE_W-1:0] in_request_blocks,
  input  logic [OFF_W-1:0]  in_free_offset,
  output bba_stat_t         stat,
  output logic              out_valid,
  output logic              out_status,
  output logic [OFF_W-1:0]  out_block_offset,
  output logic [SIZE_W-1:0] out_granted_blocks
);

  logic [SIZE_W-1:0] tree_mem [0:TREE_DEPTH-1];

  logic [ADDR_W-1:0] init_h_r;
  logic [SIZE_W-1:0] init_val_r;
  logic              out_valid_r;

  logic              kind_r;
  logic              too_big_r;
  logic [K_W-1:0]    wk_r;
  logic [SIZE_W-1:0] want_r;
  logic [OFF_W-1:0]  off_r;
  logic [ADDR_W-1:0] h_r, h_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [SIZE_W-1:0] cur_r, cur_nxt;
  logic [SIZE_W-1:0] rd0_r, rd1_r;
  logic              res_status_r;
  logic [OFF_W-1:0]  res_off_r;
  logic [SIZE_W-1:0] res_size_r;

  logic [K_W-1:0]    in_wk;
  logic [ADDR_W-1:0] leaf_in;
  logic [ADDR_W-1:0] left, right, chosen, parent;
  logic [SIZE_W-1:0] psize, maxv, newval, mark_val;
  logic [SIZE_W:0]   pair_sum;
  logic [ADDR_W-1:0] ra0, ra1, wa;
  logic [SIZE_W-1:0] wd;
  logic              we;

  assign in_wk   = ceil_log2(in_request_blocks);
  assign leaf_in = ADDR_W'(NUM_BLOCKS) + {1'b0, in_free_offset};

  // descent: smaller child that still fits
  assign left  = {h_r[ADDR_W-2:0], 1'b0};
  assign right = {h_r[ADDR_W-2:0], 1'b1};
  always_comb begin
    if (rd0_r <= rd1_r) begin
      chosen = (rd0_r >= want_r) ? left : right;
    end else begin
      chosen = (rd1_r >= want_r) ? right : left;
    end
  end

  // climb: rebuild the parent from the carried child and its buddy
  assign parent   = h_r >> 1;
  assign psize    = pow2(K_W'(k_r + K_W'(1)));
  assign pair_sum = {1'b0, cur_r} + {1'b0, rd0_r};
  assign maxv     = (cur_r > rd0_r) ? cur_r : rd0_r;
  assign newval   = (kind_r && (pair_sum == {1'b0, psize})) ? psize : maxv;
  assign mark_val = kind_r ? pow2(k_r) : '0;

  always_comb begin
    h_nxt   = h_r;
    k_nxt   = k_r;
    cur_nxt = cur_r;
    ra0     = '0;
    ra1     = '0;
    we      = 1'b0;
    wa      = '0;
    wd      = '0;
    if (cmd.init_step) begin
      we = 1'b1;
      wa = init_h_r;
      wd = init_val_r;
    end
    if (cmd.load) begin
      h_nxt = in_kind ? leaf_in : ADDR_W'(1);
      k_nxt = in_kind ? '0 : K_W'(LOG2_BLOCKS);
      ra0   = in_kind ? leaf_in : ADDR_W'(1);
    end
    if (cmd.check) begin
      ra0 = left;
      ra1 = right;
    end
    if (cmd.desc) begin
      h_nxt = chosen;
      k_nxt = K_W'(k_r - K_W'(1));
      ra0   = {chosen[ADDR_W-2:0], 1'b0};
      ra1   = {chosen[ADDR_W-2:0], 1'b1};
    end
    if (cmd.fscan) begin
      h_nxt = parent;
      k_nxt = K_W'(k_r + K_W'(1));
      ra0   = parent;
    end
    if (cmd.mark) begin
      cur_nxt = mark_val;
      ra0     = h_r ^ ADDR_W'(1);
      we      = 1'b1;
      wa      = h_r;
      wd      = mark_val;
    end
    if (cmd.climb) begin
      h_nxt   = parent;
      k_nxt   = K_W'(k_r + K_W'(1));
      cur_nxt = newval;
      ra0     = parent ^ ADDR_W'(1);
      we      = 1'b1;
      wa      = parent;
      wd      = newval;
    end
  end

  always_ff @(posedge clk) begin
    if (we) tree_mem[wa] <= wd;
    rd0_r <= tree_mem[ra0];
    rd1_r <= tree_mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      init_h_r    <= ADDR_W'(1);
      init_val_r  <= SIZE_W'(NUM_BLOCKS);
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.init_step) begin
        init_h_r <= init_h_r + ADDR_W'(1);
        // next node opens a new level: half the run
        if (((init_h_r + ADDR_W'(1)) & init_h_r) == '0) init_val_r <= init_val_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    if (cmd.load) begin
      kind_r    <= in_kind;
      wk_r      <= in_wk;
      want_r    <= pow2(in_wk);
      too_big_r <= (in_wk > K_W'(LOG2_BLOCKS));
      off_r     <= in_free_offset;
    end
    if (cmd.mark) begin
      res_status_r <= 1'b0;
      res_off_r    <= node_offset(h_r, k_r);
      res_size_r   <= pow2(k_r);
    end
    if (cmd.fail) begin
      res_status_r <= 1'b1;
      res_off_r    <= kind_r ? off_r : '0;
      res_size_r   <= '0;
    end
  end

  assign stat.init_last   = (init_h_r == {ADDR_W{1'b1}});
  assign stat.alloc_fail  = too_big_r || (rd0_r < want_r);
  assign stat.root_target = (k_r == wk_r);
  assign stat.desc_last   = (K_W'(k_r - K_W'(1)) == wk_r);
  assign stat.at_root     = (h_r == ADDR_W'(1));
  assign stat.climb_last  = (parent == ADDR_W'(1));
  assign stat.scan_hit    = (rd0_r == '0);

  assign out_valid          = out_valid_r;
  assign out_status         = res_status_r;
  assign out_block_offset   = res_off_r;
  assign out_granted_blocks = res_size_r;

endmodule

// ===== hw/rtl/buddy_block_allocator_top.sv =====
`timescale 1ns / 1ps
// buddy block allocator: 1024-block pool managed as a binary tree of largest free runs
// depends on bba_pkg, bba_ctrl, bba_dp
//
// usage
//   command channel: raise start with in_kind, in_request_blocks and in_free_offset; the
//   word is taken at a clock edge where start is high and busy is low
//   in_kind 0 asks for a region of in_request_blocks blocks (rounded up to a power of
//   two, zero counts as one); in_kind 1 releases the region holding in_free_offset
//   result channel: out_valid is high for exactly one cycle with out_status,
//   out_block_offset and out_granted_blocks; the receiver cannot hold it off
// timing
//   one word at a time; the tree memory is read once per level on the way down and
//   once per level on the way back up
//   allocate: descends from the root to a node of the granted size, marks it and
//   climbs back to the root; an allocate that does not fit fails at the root check
//   free: scans up from the leaf for the allocated node and fails if there is none
//   busy drops in the cycle out_valid is shown, so the next word can follow at once
// reset
//   after rst_n a clearing pass loads every tree node with its size, one node a
//   cycle, with busy high; after that the whole pool is free

module buddy_block_allocator_top import bba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [SIZE_W-1:0] in_request_blocks,
  input  logic [OFF_W-1:0]  in_free_offset,
  output logic              out_valid,
  output logic              out_status,
  output logic [OFF_W-1:0]  out_block_offset,
  output logic [SIZE_W-1:0] out_granted_blocks
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // sequencer: walks the tree level by level
  bba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // tree memory, walk registers and result word
  bba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_kind            (in_kind),
    .in_request_blocks  (in_request_blocks),
    .in_free_offset     (in_free_offset),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_block_offset   (out_block_offset),
    .out_granted_blocks (out_granted_blocks)
  );

  // an accepted word keeps the block occupied
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // a result only ends a period of work
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // a failure grants nothing
  a_fail_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_granted_blocks == '0)
    else $error("failure with non-zero size");

  // a success is one power-of-two region aligned to its own size
  a_ok_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> $onehot(out_granted_blocks))
    else $error("granted size not a power of two");

  a_ok_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |->
      (({1'b0, out_block_offset} & (out_granted_blocks - SIZE_W'(1))) == '0))
    else $error("region not aligned to its size");

endmodule
